// ===== design/pccl_pkg.sv =====
// shared types, constants and the cordic angle table for the corner length block
package pccl_pkg;

	localparam int CoordWidth = 32;
	localparam int CordicSteps = 24;
	localparam int StepWidth = 5;
	localparam int FifoDepth = 2;

	localparam logic signed [63:0] PiQ30 = 64'sd3373259426;
	localparam logic signed [63:0] HalfPiQ30 = 64'sd1686629713;
	localparam logic signed [63:0] KinvQ30 = 64'sd652032874;
	localparam logic [31:0] CornerKQ30 = 32'd1205374825;
	localparam logic signed [63:0] OneQ30 = 64'sd1073741824;
	localparam logic [16:0] BetaMax = 17'd102944;
	localparam logic [63:0] FitLimit = 64'd536870912;

	// one corner to be worked: the three points
	typedef struct packed {
		logic signed [CoordWidth-1:0] ax, ay, az;
		logic signed [CoordWidth-1:0] bx, by, bz;
		logic signed [CoordWidth-1:0] cx, cy, cz;
	} corner_t;

	typedef struct packed {
		logic [31:0] corner_length;
		logic [16:0] half_turn_angle;
		logic length_saturated;
	} result_t;

	function automatic logic signed [63:0] atan_q30(input logic [StepWidth-1:0] i);
		logic signed [63:0] r;
		case (i)
			5'd0: r = 64'sd843314857;
			5'd1: r = 64'sd497837829;
			5'd2: r = 64'sd263043837;
			5'd3: r = 64'sd133525159;
			5'd4: r = 64'sd67021687;
			5'd5: r = 64'sd33543516;
			5'd6: r = 64'sd16775851;
			5'd7: r = 64'sd8388437;
			5'd8: r = 64'sd4194283;
			5'd9: r = 64'sd2097149;
			default: r = 64'sd1 <<< (6'd30 - {1'b0, i});
		endcase
		return r;
	endfunction

endpackage

// ===== design/path_corner_curvature_length.sv =====
// Corner half-angle and curvature-limited corner length for a 3D waypoint stream. A waypoint
// word is taken while the two-entry corner queue has room; each corner then occupies the
// shared back-end sequencer through nine products, three squares, a bit-serial square root,
// two 24-step CORDIC passes and two bit-serial divisions, which sets the sustained rate.
// Results wait in a one-word output register until popped, and the back end takes no further
// corner while that register is full.
module path_corner_curvature_length (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic push,
	output logic full,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic signed [31:0] point_z,
	input logic path_start,
	output logic empty,
	input logic pop,
	output logic [31:0] corner_length,
	output logic [16:0] half_turn_angle,
	output logic length_saturated
);
	logic [31:0] turn_radius_q;
	logic take, emit, qfull, qhas, qrd, rv;
	pccl_pkg::corner_t cw, cr;
	pccl_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) turn_radius_q <= 32'd65536;
		else if (cfg_we) turn_radius_q <= cfg_wdata;
	end

	assign full = qfull;
	assign take = push && !qfull;

	pccl_front u_front (.clk, .arst_n, .take, .px(point_x), .py(point_y), .pz(point_z),
		.start(path_start), .emit, .corner(cw));

	pccl_queue u_queue (.clk, .arst_n, .wr(emit), .wdata(cw), .full(qfull), .rd(qrd),
		.has(qhas), .rdata(cr));

	pccl_back u_back (.clk, .arst_n, .turn_radius(turn_radius_q), .has(qhas), .corner(cr),
		.rd(qrd), .res_valid(rv), .res, .res_take(pop));

	assign empty = !rv;
	assign corner_length = res.corner_length;
	assign half_turn_angle = res.half_turn_angle;
	assign length_saturated = res.length_saturated;

	a_angle: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> half_turn_angle <= pccl_pkg::BetaMax) else $error("angle range");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && length_saturated |-> corner_length == 32'hFFFF_FFFF) else $error("sat");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(corner_length)) else $error("lost word");
endmodule

// ===== design/pccl_front.sv =====
// front part: waypoint window and corner word build-up
module pccl_front (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic signed [pccl_pkg::CoordWidth-1:0] px,
	input logic signed [pccl_pkg::CoordWidth-1:0] py,
	input logic signed [pccl_pkg::CoordWidth-1:0] pz,
	input logic start,
	output logic emit,
	output pccl_pkg::corner_t corner
);
	logic signed [pccl_pkg::CoordWidth-1:0] wx_q [2];
	logic signed [pccl_pkg::CoordWidth-1:0] wy_q [2];
	logic signed [pccl_pkg::CoordWidth-1:0] wz_q [2];
	logic [1:0] held_q;

	assign emit = take && !start && held_q == 2'd2;
	assign corner = '{ax: wx_q[0], ay: wy_q[0], az: wz_q[0],
		bx: wx_q[1], by: wy_q[1], bz: wz_q[1], cx: px, cy: py, cz: pz};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int k = 0; k < 2; k++) begin
				wx_q[k] <= '0;
				wy_q[k] <= '0;
				wz_q[k] <= '0;
			end
		end else if (take) begin
			if (start) begin
				wx_q[0] <= px;
				wy_q[0] <= py;
				wz_q[0] <= pz;
				held_q <= 2'd1;
			end else if (held_q < 2'd2) begin
				wx_q[held_q[0]] <= px;
				wy_q[held_q[0]] <= py;
				wz_q[held_q[0]] <= pz;
				held_q <= held_q + 2'd1;
			end else begin
				wx_q[0] <= wx_q[1];
				wy_q[0] <= wy_q[1];
				wz_q[0] <= wz_q[1];
				wx_q[1] <= px;
				wy_q[1] <= py;
				wz_q[1] <= pz;
			end
		end
	end
endmodule

// ===== design/pccl_queue.sv =====
// short queue between the window and the arithmetic back part
module pccl_queue (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input pccl_pkg::corner_t wdata,
	output logic full,
	input logic rd,
	output logic has,
	output pccl_pkg::corner_t rdata
);
	pccl_pkg::corner_t mem_q [pccl_pkg::FifoDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'(pccl_pkg::FifoDepth);
	assign has = cnt_q != 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

// ===== design/pccl_back.sv =====
// back part: sequencer over products, square root, cordic and division
module pccl_back (
	input logic clk,
	input logic arst_n,
	input logic [31:0] turn_radius,
	input logic has,
	input pccl_pkg::corner_t corner,
	output logic rd,
	output logic res_valid,
	output pccl_pkg::result_t res,
	input logic res_take
);
	localparam logic [3:0] StIdle = 4'd0, StDiff = 4'd1, StFit = 4'd2, StMul = 4'd3,
		StWfit = 4'd4, StSq = 4'd5, StSqrt = 4'd6, StVec = 4'd7, StRot = 4'd8,
		StPrep = 4'd9, StDiv1 = 4'd10, StDiv2 = 4'd11, StOut = 4'd12, StMulA = 4'd13,
		StFinal = 4'd14;

	logic [3:0] st_q;
	logic signed [63:0] d_q [6];
	logic signed [63:0] w_q [4];
	logic [2:0] mi_q;
	logic [63:0] acc_q, rem_q, root_q, bit_q;
	logic signed [63:0] x_q, y_q, z_q;
	logic [pccl_pkg::StepWidth-1:0] i_q;
	logic [7:0] k_q;
	logic [63:0] num_q, quo_q, dv_q;
	logic [16:0] bo_q;
	logic [63:0] aa_q;
	pccl_pkg::result_t out_q;
	logic out_v_q;

	assign rd = st_q == StIdle && has && !out_v_q;
	assign res_valid = out_v_q;
	assign res = out_q;

	function automatic logic [63:0] absu(input logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v,
		input logic [5:0] s);
		logic [63:0] a;
		a = absu(v) >> s;
		return v < 0 ? -$signed(a) : $signed(a);
	endfunction

	function automatic logic [5:0] fit_shift(input logic [63:0] m);
		logic [5:0] s;
		s = '0;
		for (int b = 0; b < 64; b++) begin
			if ((m >> b) >= pccl_pkg::FitLimit) s = 6'(b + 1);
		end
		return s;
	endfunction

	logic [63:0] m1, m2, mw;
	always_comb begin
		m1 = absu(d_q[0]) | absu(d_q[1]) | absu(d_q[2]);
		m2 = absu(d_q[3]) | absu(d_q[4]) | absu(d_q[5]);
		mw = absu(w_q[0]) | absu(w_q[1]) | absu(w_q[2]) | absu(w_q[3]);
	end

	// shared multiplier: one product per cycle over the cross and dot terms
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (mi_q)
			3'd0: begin ma = 32'(d_q[1]); mb = 32'(d_q[5]); end
			3'd1: begin ma = 32'(d_q[2]); mb = 32'(d_q[4]); end
			3'd2: begin ma = 32'(d_q[2]); mb = 32'(d_q[3]); end
			3'd3: begin ma = 32'(d_q[0]); mb = 32'(d_q[5]); end
			3'd4: begin ma = 32'(d_q[0]); mb = 32'(d_q[4]); end
			3'd5: begin ma = 32'(d_q[1]); mb = 32'(d_q[3]); end
			3'd6: begin ma = 32'(d_q[0]); mb = 32'(d_q[3]); end
			3'd7: begin ma = 32'(d_q[1]); mb = 32'(d_q[4]); end
			default: ;
		endcase
		prod = 64'(ma) * 64'(mb);
	end

	logic signed [63:0] xs, ys, at;
	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = pccl_pkg::atan_q30(i_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && res_take) out_v_q <= 1'b0;
			unique case (st_q)
				StIdle: if (rd) begin
					d_q[0] <= 64'(corner.bx) - 64'(corner.ax);
					d_q[1] <= 64'(corner.by) - 64'(corner.ay);
					d_q[2] <= 64'(corner.bz) - 64'(corner.az);
					d_q[3] <= 64'(corner.cx) - 64'(corner.bx);
					d_q[4] <= 64'(corner.cy) - 64'(corner.by);
					d_q[5] <= 64'(corner.cz) - 64'(corner.bz);
					st_q <= StDiff;
				end
				StDiff: begin
					out_q <= '0;
					if (m1 == 0 || m2 == 0) st_q <= StOut;
					else st_q <= StFit;
				end
				StFit: begin
					for (int k = 0; k < 3; k++) begin
						d_q[k] <= shr_tz(d_q[k], fit_shift(m1));
						d_q[k+3] <= shr_tz(d_q[k+3], fit_shift(m2));
					end
					mi_q <= '0;
					st_q <= StMul;
				end
				StMul: begin
					mi_q <= mi_q + 3'd1;
					unique case (mi_q)
						3'd0: w_q[0] <= prod;
						3'd1: w_q[0] <= w_q[0] - prod;
						3'd2: w_q[1] <= prod;
						3'd3: w_q[1] <= w_q[1] - prod;
						3'd4: w_q[2] <= prod;
						3'd5: w_q[2] <= w_q[2] - prod;
						3'd6: begin
							w_q[3] <= prod;
							if (w_q[0] == 0 && w_q[1] == 0 && w_q[2] == 0)
								st_q <= StOut;
						end
						3'd7: begin
							w_q[3] <= w_q[3] + prod;
							st_q <= StMulA;
						end
						default: ;
					endcase
				end
				StMulA: begin
					// last dot term, operands fixed here
					w_q[3] <= w_q[3] + 64'(32'(d_q[2])) * 64'(32'(d_q[5]));
					st_q <= StWfit;
				end
				StWfit: begin
					for (int k = 0; k < 4; k++) w_q[k] <= shr_tz(w_q[k], fit_shift(mw));
					acc_q <= '0;
					mi_q <= '0;
					st_q <= StSq;
				end
				StSq: begin
					mi_q <= mi_q + 3'd1;
					acc_q <= acc_q + 64'(64'(32'(w_q[mi_q[1:0]])) *
						64'(32'(w_q[mi_q[1:0]])));
					if (mi_q == 3'd2) begin
						bit_q <= 64'd1 << 62;
						root_q <= '0;
						st_q <= StSqrt;
					end
				end
				StSqrt: begin
					// one result bit per cycle
					if (bit_q > acc_q && root_q == 0) begin
						bit_q <= bit_q >> 2;
					end else if (bit_q == 0) begin
						if (w_q[3] < 0) begin
							x_q <= $signed(root_q);
							y_q <= -w_q[3];
							z_q <= pccl_pkg::HalfPiQ30;
						end else begin
							x_q <= w_q[3];
							y_q <= $signed(root_q);
							z_q <= '0;
						end
						i_q <= '0;
						st_q <= StVec;
					end else begin
						if (acc_q >= root_q + bit_q) begin
							acc_q <= acc_q - (root_q + bit_q);
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				StVec: begin
					if (y_q >= 0) begin
						x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + at;
					end else begin
						x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - at;
					end
					i_q <= i_q + 1'b1;
					if (i_q == pccl_pkg::StepWidth'(pccl_pkg::CordicSteps - 1)) st_q <= StPrep;
				end
				StPrep: begin
					if (i_q != 0) begin
						logic signed [63:0] zc;
						zc = z_q < 0 ? 64'sd0 : (z_q > pccl_pkg::PiQ30 ? pccl_pkg::PiQ30 : z_q);
						bo_q <= (64'(zc) + 64'd16384) >> 15 > 64'(pccl_pkg::BetaMax) ?
							pccl_pkg::BetaMax : 17'((64'(zc) + 64'd16384) >> 15);
						x_q <= pccl_pkg::KinvQ30;
						y_q <= '0;
						z_q <= zc >>> 1;
						i_q <= '0;
						st_q <= StRot;
					end else begin
						// after rotation: clamp sin and cos, form the numerator
						logic signed [63:0] c, s;
						c = x_q < 0 ? 64'sd0 : (x_q > pccl_pkg::OneQ30 ? pccl_pkg::OneQ30 : x_q);
						s = y_q < 0 ? 64'sd0 : (y_q > pccl_pkg::OneQ30 ? pccl_pkg::OneQ30 : y_q);
						dv_q <= 64'(c);
						num_q <= aa_q * 64'(s[31:0]);
						st_q <= StDiv1;
						k_q <= '0;
						quo_q <= '0;
						rem_q <= '0;
					end
				end
				StRot: begin
					if (z_q >= 0) begin
						x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - at;
					end else begin
						x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + at;
					end
					aa_q <= 64'((64'(pccl_pkg::CornerKQ30) * 64'(turn_radius)) >> 30);
					if (i_q == pccl_pkg::StepWidth'(pccl_pkg::CordicSteps - 1)) begin
						i_q <= '0;
						st_q <= StPrep;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				StDiv1: begin
					// restoring division, one quotient bit per cycle
					if (k_q == 0 && (num_q == 0 || dv_q == 0)) begin
						out_q.corner_length <= num_q == 0 ? 32'd0 : 32'hFFFF_FFFF;
						out_q.length_saturated <= num_q != 0;
						out_q.half_turn_angle <= bo_q;
						st_q <= StOut;
					end else begin
						logic [64:0] r;
						r = {rem_q, num_q[63 - k_q[5:0]]};
						if (r >= 65'(dv_q)) begin
							rem_q <= 64'(r - 65'(dv_q));
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= r[63:0];
							quo_q <= {quo_q[62:0], 1'b0};
						end
						k_q <= k_q + 8'd1;
						if (k_q == 8'd63) st_q <= StDiv2;
					end
				end
				StDiv2: begin
					if (k_q == 8'd64) begin
						if (quo_q >= (dv_q << 2)) begin
							out_q.corner_length <= 32'hFFFF_FFFF;
							out_q.length_saturated <= 1'b1;
							out_q.half_turn_angle <= bo_q;
							st_q <= StOut;
						end else begin
							num_q <= quo_q << 30;
							quo_q <= '0;
							rem_q <= '0;
							k_q <= 8'd65;
						end
					end else begin
						logic [64:0] r;
						r = {rem_q, num_q[63 - 6'(k_q - 8'd65)]};
						if (r >= 65'(dv_q)) begin
							rem_q <= 64'(r - 65'(dv_q));
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= r[63:0];
							quo_q <= {quo_q[62:0], 1'b0};
						end
						k_q <= k_q + 8'd1;
						if (k_q == 8'd128) st_q <= StFinal;
					end
				end
				StFinal: begin
					out_q.half_turn_angle <= bo_q;
					out_q.length_saturated <= quo_q > 64'hFFFF_FFFF;
					out_q.corner_length <= quo_q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : quo_q[31:0];
					st_q <= StOut;
				end
				StOut: begin
					out_v_q <= 1'b1;
					st_q <= StIdle;
				end
				default: st_q <= StIdle;
			endcase
		end
	end
endmodule
